[rtl/paired_sample_mean_rms_msd_top_assert.svh]
// Assertion macros for the paired sample statistics block.
`ifndef PAIRED_SAMPLE_MEAN_RMS_MSD_TOP_ASSERT_SVH
`define PAIRED_SAMPLE_MEAN_RMS_MSD_TOP_ASSERT_SVH

// Check that an antecedent implies a consequent on the next clock edge.
`define PSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check that a condition holds at every clock edge.
`define PSM_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`endif

[rtl/psm_pkg.sv]
`timescale 1ns / 1ps
package psm_pkg;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned CntBits    = 21;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DivBits    = 64;
  localparam logic [CntBits-1:0] CountMax = 21'h100000;

  typedef enum logic [2:0] {
    ST_ACC, ST_DIV, ST_SQRT, ST_NEXT, ST_OUT
  } state_e;

  // Divide/sqrt job selector
  typedef enum logic [2:0] {
    JOB_MEAN_A, JOB_RMS_A, JOB_MEAN_B, JOB_RMS_B, JOB_MSD
  } job_e;

  typedef struct packed {
    logic acc_en;     // accumulate the accepted pair
    logic snap;       // copy accumulators into work registers, clear them
    logic div_start;
    logic sqrt_start;
    logic store;      // store finished job result
    job_e job;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } stat_t;
endpackage

[rtl/psm_if.sv]
`timescale 1ns / 1ps
interface psm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic last_pair;
  modport source (output valid, sample_a, sample_b, last_pair, input ready);
  modport sink (input valid, sample_a, sample_b, last_pair, output ready);
endinterface

interface psm_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] mean_a;
  logic [31:0] rms_a;
  logic signed [31:0] mean_b;
  logic [31:0] rms_b;
  logic [48:0] mean_sq_diff;
  logic [20:0] count_a;
  logic [20:0] count_b;
  logic [20:0] count_both;
  logic empty_a;
  logic empty_b;
  logic empty_both;
  modport source (output valid, mean_a, rms_a, mean_b, rms_b, mean_sq_diff, count_a,
                  count_b, count_both, empty_a, empty_b, empty_both, input ready);
  modport sink (input valid, mean_a, rms_a, mean_b, rms_b, mean_sq_diff, count_a,
                count_b, count_both, empty_a, empty_b, empty_both, output ready);
endinterface

[rtl/psm_ctrl.sv]
`timescale 1ns / 1ps
module psm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  psm_pkg::stat_t  stat_i,
  output psm_pkg::ctrl_t  ctrl_o
);
  psm_pkg::state_e state_q, state_d;
  psm_pkg::job_e   job_q, job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psm_pkg::ST_ACC;
      job_q   <= psm_pkg::JOB_MEAN_A;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    ctrl_o      = '0;
    ctrl_o.job  = job_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      psm_pkg::ST_ACC: begin
        in_ready_o    = 1'b1;
        ctrl_o.acc_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          ctrl_o.snap = 1'b1;
          job_d       = psm_pkg::JOB_MEAN_A;
          state_d     = psm_pkg::ST_NEXT;
        end
      end
      psm_pkg::ST_NEXT: begin
        ctrl_o.div_start = 1'b1;
        state_d          = psm_pkg::ST_DIV;
      end
      psm_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          if (job_q == psm_pkg::JOB_RMS_A || job_q == psm_pkg::JOB_RMS_B) begin
            ctrl_o.sqrt_start = 1'b1;
            state_d           = psm_pkg::ST_SQRT;
          end else begin
            ctrl_o.store = 1'b1;
            if (job_q == psm_pkg::JOB_MSD) begin
              state_d = psm_pkg::ST_OUT;
            end else begin
              job_d   = psm_pkg::job_e'(job_q + 3'd1);
              state_d = psm_pkg::ST_NEXT;
            end
          end
        end
      end
      psm_pkg::ST_SQRT: begin
        if (stat_i.sqrt_done) begin
          ctrl_o.store = 1'b1;
          job_d        = psm_pkg::job_e'(job_q + 3'd1);
          state_d      = psm_pkg::ST_NEXT;
        end
      end
      psm_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = psm_pkg::ST_ACC;
        end
      end
      default: state_d = psm_pkg::ST_ACC;
    endcase
  end
endmodule

[rtl/psm_dp.sv]
`timescale 1ns / 1ps
module psm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic        [15:0] limit_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  input  psm_pkg::ctrl_t     ctrl_i,
  output psm_pkg::stat_t     stat_o,
  output logic signed [31:0] mean_a_o,
  output logic        [31:0] rms_a_o,
  output logic signed [31:0] mean_b_o,
  output logic        [31:0] rms_b_o,
  output logic        [48:0] msd_o,
  output logic        [20:0] na_o,
  output logic        [20:0] nb_o,
  output logic        [20:0] nj_o
);
  // Accumulators
  logic signed [36:0] sa_q, sb_q;
  logic        [50:0] qa_q, qb_q;
  logic        [52:0] qd_q;
  logic        [20:0] na_q, nb_q, nj_q;
  // Snapshot for the result phase
  logic signed [36:0] wsa_q, wsb_q;
  logic        [50:0] wqa_q, wqb_q;
  logic        [52:0] wqd_q;

  logic [16:0] maga, magb;
  logic va, vb, ua, ub, uj;
  logic signed [16:0] dif;
  logic [31:0] sqa, sqb;
  logic [33:0] sqd;

  assign maga = a_i[15] ? 17'(-{a_i[15], a_i}) : {1'b0, a_i};
  assign magb = b_i[15] ? 17'(-{b_i[15], b_i}) : {1'b0, b_i};
  assign va   = maga < {1'b0, limit_i};
  assign vb   = magb < {1'b0, limit_i};
  assign ua   = va && (na_q < psm_pkg::CountMax);
  assign ub   = vb && (nb_q < psm_pkg::CountMax);
  assign uj   = va && vb && (nj_q < psm_pkg::CountMax);
  assign dif  = 17'(a_i) - 17'(b_i);
  assign sqa  = 32'(maga * maga);
  assign sqb  = 32'(magb * magb);
  assign sqd  = 34'(dif * dif);

  logic signed [36:0] sa_n, sb_n;
  logic        [50:0] qa_n, qb_n;
  logic        [52:0] qd_n;
  logic        [20:0] na_n, nb_n, nj_n;

  always_comb begin
    sa_n = sa_q; sb_n = sb_q; qa_n = qa_q; qb_n = qb_q; qd_n = qd_q;
    na_n = na_q; nb_n = nb_q; nj_n = nj_q;
    if (ctrl_i.acc_en) begin
      if (ua) begin
        sa_n = sa_q + 37'(a_i); qa_n = qa_q + 51'(sqa); na_n = na_q + 21'd1;
      end
      if (ub) begin
        sb_n = sb_q + 37'(b_i); qb_n = qb_q + 51'(sqb); nb_n = nb_q + 21'd1;
      end
      if (uj) begin
        qd_n = qd_q + 53'(sqd); nj_n = nj_q + 21'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0; sb_q <= '0; qa_q <= '0; qb_q <= '0; qd_q <= '0;
      na_q <= '0; nb_q <= '0; nj_q <= '0;
      na_o <= '0; nb_o <= '0; nj_o <= '0;
    end else if (ctrl_i.snap) begin
      sa_q <= '0; sb_q <= '0; qa_q <= '0; qb_q <= '0; qd_q <= '0;
      na_q <= '0; nb_q <= '0; nj_q <= '0;
      na_o <= na_n; nb_o <= nb_n; nj_o <= nj_n;
    end else begin
      sa_q <= sa_n; sb_q <= sb_n; qa_q <= qa_n; qb_q <= qb_n; qd_q <= qd_n;
      na_q <= na_n; nb_q <= nb_n; nj_q <= nj_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap) begin
      wsa_q <= sa_n; wsb_q <= sb_n; wqa_q <= qa_n; wqb_q <= qb_n; wqd_q <= qd_n;
    end
  end

  // Job operands: numerator, denominator, scale, rounding
  logic [52:0] num;
  logic [20:0] den;
  logic        neg, rnd, shl32;
  always_comb begin
    num = '0; den = na_o; neg = 1'b0; rnd = 1'b1; shl32 = 1'b0;
    case (ctrl_i.job)
      psm_pkg::JOB_MEAN_A: begin
        neg = wsa_q[36];
        num = 53'(wsa_q[36] ? -wsa_q : wsa_q);
      end
      psm_pkg::JOB_RMS_A: begin
        num = 53'(wqa_q); rnd = 1'b0; shl32 = 1'b1;
      end
      psm_pkg::JOB_MEAN_B: begin
        den = nb_o; neg = wsb_q[36];
        num = 53'(wsb_q[36] ? -wsb_q : wsb_q);
      end
      psm_pkg::JOB_RMS_B: begin
        den = nb_o; num = 53'(wqb_q); rnd = 1'b0; shl32 = 1'b1;
      end
      psm_pkg::JOB_MSD: begin
        den = nj_o; num = wqd_q;
      end
      default: ;
    endcase
  end

  // Restoring divider, one quotient bit a cycle. Numerator is num<<sh<<1
  // (one extra bit for rounding: q2=floor(2*num*2^sh/den), then (q2+rnd)>>1).
  logic [86:0] dnum_q;   // shifting dividend, up to 53+32+1 bits
  logic [21:0] drem_q;
  logic [86:0] dquo_q;
  logic [6:0]  dcnt_q;
  logic        dbusy_q, neg_q, rnd_q;
  logic [21:0] rtry;
  logic [22:0] rsub;

  assign rtry = {drem_q[20:0], dnum_q[86]};
  assign rsub = {1'b0, rtry} - {2'b0, den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (ctrl_i.div_start) begin
      dbusy_q <= (den != '0);
      dcnt_q  <= 7'd87;
    end else if (dbusy_q) begin
      dcnt_q  <= dcnt_q - 7'd1;
      if (dcnt_q == 7'd1) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dnum_q <= shl32 ? {1'b0, num, 33'b0} : {17'b0, num, 17'b0};
      drem_q <= '0;
      dquo_q <= '0;
      neg_q  <= neg;
      rnd_q  <= rnd;
    end else if (dbusy_q) begin
      dnum_q <= {dnum_q[85:0], 1'b0};
      if (!rsub[22]) begin
        drem_q <= rsub[21:0];
        dquo_q <= {dquo_q[85:0], 1'b1};
      end else begin
        drem_q <= rtry;
        dquo_q <= {dquo_q[85:0], 1'b0};
      end
    end
  end

  assign stat_o.div_done = !dbusy_q;

  logic [86:0] qfin;
  assign qfin = rnd_q ? 87'((dquo_q + 87'd1) >> 1) : 87'(dquo_q >> 1);

  // Bit-pair square root over 64 bits
  logic [63:0] sx_q, sres_q, sbit_q;
  logic        sbusy_q;
  logic [64:0] strial;
  assign strial = 65'(sres_q) + 65'(sbit_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
    end else if (ctrl_i.sqrt_start) begin
      sbusy_q <= 1'b1;
    end else if (sbusy_q && sbit_q == '0) begin
      sbusy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqrt_start) begin
      sx_q   <= (qfin[86:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : qfin[63:0];
      sres_q <= '0;
      sbit_q <= 64'h4000_0000_0000_0000;
    end else if (sbusy_q && sbit_q != '0) begin
      if (65'(sx_q) >= strial) begin
        sx_q   <= sx_q - strial[63:0];
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end
  assign stat_o.sqrt_done = sbusy_q && sbit_q == '0;

  // Result store with saturation
  logic [31:0] mean_v, rms_v;
  always_comb begin
    if (neg_q) begin
      mean_v = (qfin > 87'h8000_0000) ? 32'h8000_0000 : 32'(-qfin[31:0]);
    end else begin
      mean_v = (qfin > 87'h7FFF_FFFF) ? 32'h7FFF_FFFF : qfin[31:0];
    end
    rms_v = (sres_q[63:32] != '0) ? 32'hFFFF_FFFF : sres_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store) begin
      case (ctrl_i.job)
        psm_pkg::JOB_MEAN_A: mean_a_o <= (na_o == '0) ? '0 : mean_v;
        psm_pkg::JOB_RMS_A:  rms_a_o  <= (na_o == '0) ? '0 : rms_v;
        psm_pkg::JOB_MEAN_B: mean_b_o <= (nb_o == '0) ? '0 : mean_v;
        psm_pkg::JOB_RMS_B:  rms_b_o  <= (nb_o == '0) ? '0 : rms_v;
        psm_pkg::JOB_MSD:    msd_o    <= (nj_o == '0) ? '0 : qfin[48:0];
        default: ;
      endcase
    end
  end
endmodule

[rtl/paired_sample_mean_rms_msd_top.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Carries
// in_if    | sink      | sample_a, sample_b, last_pair
// out_if   | source    | means, rms values, mean square difference, counts, flags
// cfg      | write     | ignore_limit (cfg_we_i, cfg_wdata_i)
// One ordinary pair is accepted per cycle while input ready is high.
// A last pair starts the result phase, five jobs on one shared restoring
// divider and, for the rms jobs, a bit-pair square root (32 steps); out
// valid rises once the mean square difference job is stored, sooner when
// a count is empty.
// Input ready is low from the last pair until the result is taken.
// Reset clears accumulators, state and sets ignore_limit to 32769.
`include "paired_sample_mean_rms_msd_top_assert.svh"
module paired_sample_mean_rms_msd_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  psm_in_if.sink      in_if,
  psm_out_if.source   out_if
);
  logic [15:0]     limit_q;
  psm_pkg::ctrl_t  ctrl;
  psm_pkg::stat_t  stat;

  // Hold the ignore limit; update on a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'd32769;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  psm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.last_pair),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  psm_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .limit_i  (limit_q),
    .a_i      (in_if.sample_a),
    .b_i      (in_if.sample_b),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .mean_a_o (out_if.mean_a),
    .rms_a_o  (out_if.rms_a),
    .mean_b_o (out_if.mean_b),
    .rms_b_o  (out_if.rms_b),
    .msd_o    (out_if.mean_sq_diff),
    .na_o     (out_if.count_a),
    .nb_o     (out_if.count_b),
    .nj_o     (out_if.count_both)
  );

  // Flag empty counts
  assign out_if.empty_a    = (out_if.count_a == '0);
  assign out_if.empty_b    = (out_if.count_b == '0);
  assign out_if.empty_both = (out_if.count_both == '0);

  `PSM_ASSERT_ALWAYS(a_no_overlap, clk_i, rst_ni, !(in_if.ready && out_if.valid))
  `PSM_ASSERT_NEXT(a_last_blocks, clk_i, rst_ni,
    in_if.valid && in_if.ready && in_if.last_pair, !in_if.ready)
  `PSM_ASSERT_NEXT(a_take_frees, clk_i, rst_ni, out_if.valid && out_if.ready, in_if.ready)
endmodule
